// File: hdl/gkeg_pkg.sv
// Shared types and constants of the gamepad key event generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gkeg_pkg;

  // Input word: one poll of the gamepad
  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [14:0]        left_trigger;
    logic [14:0]        right_trigger;
    logic [14:0]        button_mask;
    logic [30:0]        time_ms;
    logic               menu_mode;
  } in_word_t;

  // Result word: one key event
  typedef struct packed {
    logic [4:0] key_code;
    logic       pressed;
    logic       last_event;
  } out_word_t;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0]  trigger_threshold;
    logic        stick_toggle_enable;
    logic [14:0] left_deadzone;
    logic [14:0] right_deadzone;
    logic [15:0] initial_repeat_ms;
    logic [15:0] repeat_ms;
  } cfg_t;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_TRIG_THR   = 3'd0;
  localparam logic [2:0] REG_TOGGLE_EN  = 3'd1;
  localparam logic [2:0] REG_LEFT_DZ    = 3'd2;
  localparam logic [2:0] REG_RIGHT_DZ   = 3'd3;
  localparam logic [2:0] REG_INIT_RPT   = 3'd4;
  localparam logic [2:0] REG_RPT        = 3'd5;

  localparam logic [7:0]  RST_TRIG_THR  = 8'd30;
  localparam logic [14:0] RST_LEFT_DZ   = 15'd7849;
  localparam logic [14:0] RST_RIGHT_DZ  = 15'd8689;
  localparam logic [15:0] RST_INIT_RPT  = 16'd220;
  localparam logic [15:0] RST_RPT       = 16'd160;

  localparam int KEY_COUNT   = 25;
  localparam int REPEAT_KEYS = 12;

  localparam logic [7:0]  THR_MIN  = 8'd10;
  localparam logic [7:0]  THR_MAX  = 8'd244;
  localparam logic [14:0] DZ_MAX   = 15'd32767;
  localparam logic [23:0] MAG_CAP  = 24'd8388352;  // full scale in Q.8

  // Iterative units
  localparam int ITER_W = 5;
  localparam logic [ITER_W-1:0] SQRT_STEPS = 5'd24;
  localparam logic [ITER_W-1:0] DIV_STEPS  = 5'd17;

  // Stick direction codes
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_SQ,
    OP_SUM,
    OP_SQRT,
    OP_PREP,
    OP_DIV,
    OP_NN,
    OP_MUL,
    OP_CMP,
    OP_DIR,
    OP_EVAL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   stick;   // 0 left, 1 right
    logic   prev;    // work on the previous poll's axes
    logic   zero;    // direction result forced to none
    logic   comp_y;  // component under test is y
  } cmd_t;

  typedef struct packed {
    logic       menu;
    logic       early_none;
    logic       n_zero;
    logic [1:0] prev_ok;
    logic       evt_any;
    logic       evt_last;
    logic       out_free;
  } sts_t;

endpackage

// File: hdl/gkeg_cfg.sv
// Configuration register file on an APB-style port.
// Depends on gkeg_pkg for cfg_t, register indexes and reset values.
module gkeg_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gkeg_pkg::cfg_t      cfg
);

  gkeg_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_threshold   <= gkeg_pkg::RST_TRIG_THR;
      cfg_r.stick_toggle_enable <= 1'b0;
      cfg_r.left_deadzone       <= gkeg_pkg::RST_LEFT_DZ;
      cfg_r.right_deadzone      <= gkeg_pkg::RST_RIGHT_DZ;
      cfg_r.initial_repeat_ms   <= gkeg_pkg::RST_INIT_RPT;
      cfg_r.repeat_ms           <= gkeg_pkg::RST_RPT;
    end else if (wr_en) begin
      case (idx)
        gkeg_pkg::REG_TRIG_THR:  cfg_r.trigger_threshold   <= pwdata[7:0];
        gkeg_pkg::REG_TOGGLE_EN: cfg_r.stick_toggle_enable <= pwdata[0];
        gkeg_pkg::REG_LEFT_DZ:   cfg_r.left_deadzone       <= pwdata[14:0];
        gkeg_pkg::REG_RIGHT_DZ:  cfg_r.right_deadzone      <= pwdata[14:0];
        gkeg_pkg::REG_INIT_RPT:  cfg_r.initial_repeat_ms   <= pwdata[15:0];
        gkeg_pkg::REG_RPT:       cfg_r.repeat_ms           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      gkeg_pkg::REG_TRIG_THR:  prdata = {24'd0, cfg_r.trigger_threshold};
      gkeg_pkg::REG_TOGGLE_EN: prdata = {31'd0, cfg_r.stick_toggle_enable};
      gkeg_pkg::REG_LEFT_DZ:   prdata = {17'd0, cfg_r.left_deadzone};
      gkeg_pkg::REG_RIGHT_DZ:  prdata = {17'd0, cfg_r.right_deadzone};
      gkeg_pkg::REG_INIT_RPT:  prdata = {16'd0, cfg_r.initial_repeat_ms};
      gkeg_pkg::REG_RPT:       prdata = {16'd0, cfg_r.repeat_ms};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// File: hdl/gkeg_dp.sv
// Datapath: poll capture, stick direction arithmetic (square, root, divide,
// threshold compare), event mask build, repeat state and result register.
// Depends on gkeg_pkg; driven by gkeg_ctrl through cmd_t, reports sts_t.
module gkeg_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gkeg_pkg::in_word_t    in_word,
  input  gkeg_pkg::cfg_t        cfg,
  input  gkeg_pkg::cmd_t        cmd,
  output gkeg_pkg::sts_t        sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gkeg_pkg::out_word_t   out_word
);

  // poll and history
  gkeg_pkg::in_word_t in_r;
  logic signed [15:0] prev_ax_r [4];
  logic [14:0]        prev_trig_r [2];
  logic [14:0]        prev_btn_r;
  logic [30:0]        rlt_r [gkeg_pkg::REPEAT_KEYS];
  logic [gkeg_pkg::REPEAT_KEYS-1:0] started_r;
  logic [1:0]         latch_r;
  logic [2:0]         newdir_r [2];
  logic [2:0]         prevdir_r [2];
  logic [1:0]         prev_ok_r;
  logic [14:0]        prev_dz_r [2];

  // arithmetic
  logic [30:0] xsq_r, ysq_r;
  logic [29:0] dzsq_r;
  logic [14:0] dz_r;
  logic        xpos_r, xneg_r, ypos_r, yneg_r;
  logic [31:0] sumsq_r;
  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic [14:0] dvs_r;
  logic [14:0] drem_r;
  logic [16:0] dd_r;
  logic [16:0] quo_r;
  logic [32:0] nn_r;
  logic [46:0] pl_r;
  logic [47:0] ph_r;
  logic        gtx_r, gty_r;

  // events and output
  logic [gkeg_pkg::KEY_COUNT-1:0] ev_mask_r, ev_press_r;
  logic                           out_valid_r;
  gkeg_pkg::out_word_t            out_word_r;

  // ---- operand select for the current stick job
  logic signed [15:0] xs, ys;
  logic [14:0]        dz_sel;
  logic signed [31:0] xx, yy;
  logic [29:0]        dzdz;

  always_comb begin
    if (cmd.stick) begin
      xs     = cmd.prev ? prev_ax_r[2] : in_r.right_x;
      ys     = cmd.prev ? prev_ax_r[3] : in_r.right_y;
      dz_sel = cfg.right_deadzone;
    end else begin
      xs     = cmd.prev ? prev_ax_r[0] : in_r.left_x;
      ys     = cmd.prev ? prev_ax_r[1] : in_r.left_y;
      dz_sel = cfg.left_deadzone;
    end
  end

  assign xx   = xs * xs;
  assign yy   = ys * ys;
  assign dzdz = dz_sel * dz_sel;

  // ---- root step: one result bit per cycle
  logic [27:0] rem_sh, trial;
  logic        rt_ge;
  assign rem_sh = {rem_r, rad_r[47:46]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign rt_ge  = rem_sh >= trial;

  // ---- cap, subtract deadzone, set up divide
  logic [23:0] mag_c;
  logic [23:0] num_w;
  logic [30:0] dividend;
  assign mag_c    = (root_r > gkeg_pkg::MAG_CAP) ? gkeg_pkg::MAG_CAP : root_r;
  assign num_w    = mag_c - {1'b0, dz_r, 8'd0};
  assign dividend = {num_w[22:0], 8'd0};

  // ---- restoring divide step
  logic [15:0] r_sh;
  logic        dv_ge;
  assign r_sh  = {drem_r, dd_r[16]};
  assign dv_ge = r_sh >= {1'b0, dvs_r};

  // ---- squares of the fraction and component products
  logic [33:0] nn_full;
  logic [30:0] csq;
  logic [63:0] prod, rhs;
  assign nn_full = quo_r * quo_r;
  assign csq     = cmd.comp_y ? ysq_r : xsq_r;
  assign prod    = {17'd0, pl_r} + {ph_r, 16'd0};
  assign rhs     = {1'b0, sumsq_r, 31'd0};

  // ---- direction from the threshold flags
  logic [2:0] dir_val;
  always_comb begin
    if (cmd.zero)             dir_val = gkeg_pkg::DIR_NONE;
    else if (gtx_r && xpos_r) dir_val = gkeg_pkg::DIR_RIGHT;
    else if (gtx_r && xneg_r) dir_val = gkeg_pkg::DIR_LEFT;
    else if (gty_r && yneg_r) dir_val = gkeg_pkg::DIR_UP;
    else if (gty_r && ypos_r) dir_val = gkeg_pkg::DIR_DOWN;
    else                      dir_val = gkeg_pkg::DIR_NONE;
  end

  // ---- event evaluation
  logic [14:0] nb, ob;
  logic [30:0] now;
  logic        menu;
  logic [7:0]  thr;
  logic [gkeg_pkg::REPEAT_KEYS-1:0] fire, hold, drop;
  logic [gkeg_pkg::KEY_COUNT-1:0]   ev_mask, ev_press;
  logic [30:0] rlt_nxt [gkeg_pkg::REPEAT_KEYS];
  logic [gkeg_pkg::REPEAT_KEYS-1:0] started_nxt;
  logic [1:0]  latch_nxt;
  logic [15:0] delay;
  logic [31:0] due;
  logic        t_new, t_old;

  assign nb   = in_r.button_mask;
  assign ob   = prev_btn_r;
  assign now  = in_r.time_ms;
  assign menu = in_r.menu_mode;

  always_comb begin
    if (cfg.trigger_threshold < gkeg_pkg::THR_MIN)      thr = gkeg_pkg::THR_MIN;
    else if (cfg.trigger_threshold > gkeg_pkg::THR_MAX) thr = gkeg_pkg::THR_MAX;
    else                                                thr = cfg.trigger_threshold;
  end

  always_comb begin
    ev_mask     = '0;
    ev_press    = '0;
    started_nxt = started_r;
    latch_nxt   = latch_r;
    fire        = '0;
    hold        = '0;
    drop        = '0;
    delay       = '0;
    due         = '0;
    t_new       = 1'b0;
    t_old       = 1'b0;
    for (int k = 0; k < gkeg_pkg::REPEAT_KEYS; k++) begin
      rlt_nxt[k] = rlt_r[k];
    end

    // repeat timers: a key is due once its delay has passed or time has gone back
    for (int k = 0; k < gkeg_pkg::REPEAT_KEYS; k++) begin
      delay   = started_r[k] ? cfg.repeat_ms : cfg.initial_repeat_ms;
      due     = {1'b0, rlt_r[k]} + {16'd0, delay};
      fire[k] = ({1'b0, now} > due) || (now < rlt_r[k]);
    end

    // stick and d-pad hold / release requests
    for (int j = 0; j < 4; j++) begin
      hold[j]     = newdir_r[0] == 3'(j + 1);
      drop[j]     = !hold[j] && (prevdir_r[0] == 3'(j + 1));
      hold[4 + j] = newdir_r[1] == 3'(j + 1);
      drop[4 + j] = !hold[4 + j] && (prevdir_r[1] == 3'(j + 1));
      hold[8 + j] = nb[11 + j];
      drop[8 + j] = !nb[11 + j] && ob[11 + j];
    end

    if (menu) begin
      for (int k = 0; k < gkeg_pkg::REPEAT_KEYS; k++) begin
        if (hold[k] && fire[k]) begin
          ev_mask[k]     = 1'b1;
          ev_press[k]    = 1'b1;
          rlt_nxt[k]     = now;
          started_nxt[k] = 1'b1;
        end
        if (drop[k]) begin
          ev_mask[k]     = 1'b1;
          ev_press[k]    = 1'b0;
          rlt_nxt[k]     = '0;
          started_nxt[k] = 1'b0;
        end
      end
    end else begin
      // d-pad on edges
      for (int j = 0; j < 4; j++) begin
        ev_mask[8 + j]  = nb[11 + j] ^ ob[11 + j];
        ev_press[8 + j] = nb[11 + j];
      end
    end

    // face buttons, back, guide, start
    for (int j = 0; j < 7; j++) begin
      ev_mask[12 + j]  = nb[j] ^ ob[j];
      ev_press[12 + j] = nb[j];
    end

    // stick buttons: edges, or toggles outside menu mode when toggling is enabled
    for (int j = 0; j < 2; j++) begin
      if (!cfg.stick_toggle_enable || menu) begin
        latch_nxt[j]     = 1'b0;
        ev_mask[19 + j]  = nb[7 + j] ^ ob[7 + j];
        ev_press[19 + j] = nb[7 + j];
      end else if (nb[7 + j] && !ob[7 + j]) begin
        latch_nxt[j]     = !latch_r[j];
        ev_mask[19 + j]  = 1'b1;
        ev_press[19 + j] = !latch_r[j];
      end
    end

    // shoulders
    for (int j = 0; j < 2; j++) begin
      ev_mask[21 + j]  = nb[9 + j] ^ ob[9 + j];
      ev_press[21 + j] = nb[9 + j];
    end

    // triggers against the clamped threshold
    for (int j = 0; j < 2; j++) begin
      t_new            = (j == 0 ? in_r.left_trigger : in_r.right_trigger) >= {7'd0, thr};
      t_old            = prev_trig_r[j] >= {7'd0, thr};
      ev_mask[23 + j]  = t_new ^ t_old;
      ev_press[23 + j] = t_new;
    end
  end

  // ---- pick the lowest pending event
  logic [gkeg_pkg::KEY_COUNT-1:0] ev_one;
  logic [4:0]                     ev_code;
  assign ev_one = ev_mask_r & (~ev_mask_r + 1'b1);
  always_comb begin
    ev_code = '0;
    for (int k = 0; k < gkeg_pkg::KEY_COUNT; k++) begin
      if (ev_one[k]) ev_code = ev_code | 5'(k);
    end
  end

  // ---- status
  always_comb begin
    sts.menu       = in_r.menu_mode;
    sts.early_none = (dz_r == gkeg_pkg::DZ_MAX) || (sumsq_r <= {2'b00, dzsq_r});
    sts.n_zero     = quo_r == '0;
    sts.prev_ok[0] = prev_ok_r[0] && (prev_dz_r[0] == cfg.left_deadzone);
    sts.prev_ok[1] = prev_ok_r[1] && (prev_dz_r[1] == cfg.right_deadzone);
    sts.evt_any    = |ev_mask_r;
    sts.evt_last   = (ev_mask_r & ~ev_one) == '0;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // ---- arithmetic registers (no reset needed)
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gkeg_pkg::OP_CAPTURE: in_r <= in_word;
      gkeg_pkg::OP_SQ: begin
        xsq_r  <= xx[30:0];
        ysq_r  <= yy[30:0];
        dzsq_r <= dzdz;
        dz_r   <= dz_sel;
        xpos_r <= !xs[15] && (xs != '0);
        xneg_r <= xs[15];
        ypos_r <= !ys[15] && (ys != '0);
        yneg_r <= ys[15];
      end
      gkeg_pkg::OP_SUM: begin
        sumsq_r <= {1'b0, xsq_r} + {1'b0, ysq_r};
        rad_r   <= {({1'b0, xsq_r} + {1'b0, ysq_r}), 16'd0};
        rem_r   <= '0;
        root_r  <= '0;
      end
      gkeg_pkg::OP_SQRT: begin
        rem_r  <= rt_ge ? 26'(rem_sh - trial) : 26'(rem_sh);
        root_r <= {root_r[22:0], rt_ge};
        rad_r  <= {rad_r[45:0], 2'b00};
      end
      gkeg_pkg::OP_PREP: begin
        dvs_r  <= gkeg_pkg::DZ_MAX - dz_r;
        drem_r <= {1'b0, dividend[30:17]};
        dd_r   <= dividend[16:0];
        quo_r  <= '0;
      end
      gkeg_pkg::OP_DIV: begin
        drem_r <= dv_ge ? 15'(r_sh - {1'b0, dvs_r}) : 15'(r_sh);
        quo_r  <= {quo_r[15:0], dv_ge};
        dd_r   <= {dd_r[15:0], 1'b0};
      end
      gkeg_pkg::OP_NN: nn_r <= nn_full[32:0];
      gkeg_pkg::OP_MUL: begin
        pl_r <= csq * nn_r[15:0];
        ph_r <= csq * nn_r[32:16];
      end
      gkeg_pkg::OP_CMP: begin
        if (cmd.comp_y) gty_r <= prod > rhs;
        else            gtx_r <= prod > rhs;
      end
      default: ;
    endcase
  end

  // ---- direction results and their cache tag
  always_ff @(posedge clk) begin
    if (cmd.op == gkeg_pkg::OP_DIR) begin
      if (cmd.prev) prevdir_r[cmd.stick] <= dir_val;
      else          newdir_r[cmd.stick]  <= dir_val;
    end else if (cmd.op == gkeg_pkg::OP_EVAL && menu) begin
      prevdir_r[0] <= newdir_r[0];
      prevdir_r[1] <= newdir_r[1];
      prev_dz_r[0] <= cfg.left_deadzone;
      prev_dz_r[1] <= cfg.right_deadzone;
    end
  end

  // ---- key state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 4; a++) prev_ax_r[a] <= '0;
      prev_trig_r[0] <= '0;
      prev_trig_r[1] <= '0;
      prev_btn_r     <= '0;
      for (int k = 0; k < gkeg_pkg::REPEAT_KEYS; k++) rlt_r[k] <= '0;
      started_r      <= '0;
      latch_r        <= '0;
      prev_ok_r      <= '0;
    end else if (cmd.op == gkeg_pkg::OP_EVAL) begin
      prev_ax_r[0]   <= in_r.left_x;
      prev_ax_r[1]   <= in_r.left_y;
      prev_ax_r[2]   <= in_r.right_x;
      prev_ax_r[3]   <= in_r.right_y;
      prev_trig_r[0] <= in_r.left_trigger;
      prev_trig_r[1] <= in_r.right_trigger;
      prev_btn_r     <= nb;
      for (int k = 0; k < gkeg_pkg::REPEAT_KEYS; k++) rlt_r[k] <= rlt_nxt[k];
      started_r      <= started_nxt;
      latch_r        <= latch_nxt;
      prev_ok_r      <= {menu, menu};
    end
  end

  // ---- pending events and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_mask_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == gkeg_pkg::OP_EVAL) begin
        ev_mask_r <= ev_mask;
      end else if (cmd.op == gkeg_pkg::OP_EMIT) begin
        ev_mask_r <= ev_mask_r & ~ev_one;
      end
      if (cmd.op == gkeg_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gkeg_pkg::OP_EVAL) ev_press_r <= ev_press;
    if (cmd.op == gkeg_pkg::OP_EMIT) begin
      out_word_r.key_code   <= ev_code;
      out_word_r.pressed    <= |(ev_one & ev_press_r);
      out_word_r.last_event <= sts.evt_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: hdl/gkeg_ctrl.sv
// Controller: sequences capture, the per-stick direction jobs, the event
// evaluation and the event emission. Depends on gkeg_pkg (cmd_t, sts_t).
module gkeg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gkeg_pkg::sts_t   sts,
  output gkeg_pkg::cmd_t   cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_START  = 16'b0000_0000_0000_0010,
    S_SQ     = 16'b0000_0000_0000_0100,
    S_SUM    = 16'b0000_0000_0000_1000,
    S_CHK    = 16'b0000_0000_0001_0000,
    S_SQRT   = 16'b0000_0000_0010_0000,
    S_PREP   = 16'b0000_0000_0100_0000,
    S_DIV    = 16'b0000_0000_1000_0000,
    S_NN     = 16'b0000_0001_0000_0000,
    S_MULX   = 16'b0000_0010_0000_0000,
    S_CMPX   = 16'b0000_0100_0000_0000,
    S_MULY   = 16'b0000_1000_0000_0000,
    S_CMPY   = 16'b0001_0000_0000_0000,
    S_SETDIR = 16'b0010_0000_0000_0000,
    S_EVAL   = 16'b0100_0000_0000_0000,
    S_EMIT   = 16'b1000_0000_0000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [gkeg_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                        stick_r, stick_nxt;
  logic                        prev_r, prev_nxt;

  // next stick job: previous poll if its cached direction is stale, then right stick
  state_t nj_state;
  logic   nj_stick, nj_prev;
  always_comb begin
    if (!prev_r && !sts.prev_ok[stick_r]) begin
      nj_state = S_SQ;
      nj_stick = stick_r;
      nj_prev  = 1'b1;
    end else if (!stick_r) begin
      nj_state = S_SQ;
      nj_stick = 1'b1;
      nj_prev  = 1'b0;
    end else begin
      nj_state = S_EVAL;
      nj_stick = stick_r;
      nj_prev  = prev_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    iter_nxt   = iter_r;
    stick_nxt  = stick_r;
    prev_nxt   = prev_r;
    in_ready   = 1'b0;
    cmd.op     = gkeg_pkg::OP_NOP;
    cmd.stick  = stick_r;
    cmd.prev   = prev_r;
    cmd.zero   = 1'b0;
    cmd.comp_y = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = gkeg_pkg::OP_CAPTURE;
          state_nxt = S_START;
        end
      end
      S_START: begin
        stick_nxt = 1'b0;
        prev_nxt  = 1'b0;
        state_nxt = sts.menu ? S_SQ : S_EVAL;
      end
      S_SQ: begin
        cmd.op    = gkeg_pkg::OP_SQ;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = gkeg_pkg::OP_SUM;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // inside the deadzone: no direction, skip the arithmetic
        if (sts.early_none) begin
          cmd.op    = gkeg_pkg::OP_DIR;
          cmd.zero  = 1'b1;
          state_nxt = nj_state;
          stick_nxt = nj_stick;
          prev_nxt  = nj_prev;
        end else begin
          iter_nxt  = gkeg_pkg::SQRT_STEPS - 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = gkeg_pkg::OP_SQRT;
        if (iter_r == '0) state_nxt = S_PREP;
        else              iter_nxt  = iter_r - 1'b1;
      end
      S_PREP: begin
        cmd.op    = gkeg_pkg::OP_PREP;
        iter_nxt  = gkeg_pkg::DIV_STEPS - 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = gkeg_pkg::OP_DIV;
        if (iter_r == '0) state_nxt = S_NN;
        else              iter_nxt  = iter_r - 1'b1;
      end
      S_NN: begin
        if (sts.n_zero) begin
          cmd.op    = gkeg_pkg::OP_DIR;
          cmd.zero  = 1'b1;
          state_nxt = nj_state;
          stick_nxt = nj_stick;
          prev_nxt  = nj_prev;
        end else begin
          cmd.op    = gkeg_pkg::OP_NN;
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cmd.op    = gkeg_pkg::OP_MUL;
        state_nxt = S_CMPX;
      end
      S_CMPX: begin
        cmd.op    = gkeg_pkg::OP_CMP;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.op     = gkeg_pkg::OP_MUL;
        cmd.comp_y = 1'b1;
        state_nxt  = S_CMPY;
      end
      S_CMPY: begin
        cmd.op     = gkeg_pkg::OP_CMP;
        cmd.comp_y = 1'b1;
        state_nxt  = S_SETDIR;
      end
      S_SETDIR: begin
        cmd.op    = gkeg_pkg::OP_DIR;
        state_nxt = nj_state;
        stick_nxt = nj_stick;
        prev_nxt  = nj_prev;
      end
      S_EVAL: begin
        cmd.op    = gkeg_pkg::OP_EVAL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.evt_any) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.op = gkeg_pkg::OP_EMIT;
          if (sts.evt_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      stick_r <= 1'b0;
      prev_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      stick_r <= stick_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// File: hdl/gamepad_key_event_generator.sv
// Gamepad key event generator: one poll word in, zero to 21 key event words out.
// Outside menu mode a poll skips the stick jobs and goes to evaluation. In menu mode each
// stick direction job stops after the deadzone check inside the deadzone, after the divide
// when the scaled magnitude is zero, else after the compares (24-step root, 17-step divide);
// 2 jobs per poll, 4 after reset, a deadzone change or a non-menu poll; then evaluation. One
// word per cycle follows while the output is free; idle and ready again after the last word.
// Reset (rst_n low, synchronous): registers to defaults, history and repeat state zero.
module gamepad_key_event_generator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gkeg_pkg::in_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gkeg_pkg::out_word_t   out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  gkeg_pkg::cfg_t cfg;
  gkeg_pkg::cmd_t cmd;
  gkeg_pkg::sts_t sts;

  // configuration registers
  gkeg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  gkeg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, key state and result register
  gkeg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
